[hdl/memory_node_selector_macros.svh]
// Assertion macros for the memory node selector.
`ifndef MEMORY_NODE_SELECTOR_MACROS_SVH
`define MEMORY_NODE_SELECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MNSEL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MNSEL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mnsel_pkg.sv]
// Shared types and constants of the memory node selector.
`default_nettype none
package mnsel_pkg;
    localparam int ID_W    = 8;
    localparam int RAM_W   = 48;
    localparam int CNT_W   = 32;
    localparam int PHASE_W = 16;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 184;
    localparam int OUT_DATA_W = 56;

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_CONSULT = 1'b1;

    localparam logic [MODE_W-1:0] MODE_RR      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRAFFIC = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd5;

    typedef struct packed {
        logic [RAM_W-1:0] total_ram;
        logic [RAM_W-1:0] free_ram;
        logic [CNT_W-1:0] request_count;
    } t_slot_data;
endpackage
`default_nettype wire

[hdl/mnsel_table.sv]
// Slot status table: one write port, one scan read port, cleared at reset.
`default_nettype none
module mnsel_table #(
    parameter int DEPTH = 4,
    parameter int IDX_W = 2
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_wr_en,
    input  wire logic [IDX_W-1:0]    i_wr_idx,
    input  wire mnsel_pkg::t_slot_data i_wr_data,
    input  wire logic [IDX_W-1:0]    i_rd_idx,
    output mnsel_pkg::t_slot_data    o_rd_data
);
    import mnsel_pkg::*;

    t_slot_data r_slot [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_slot[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_slot[i_wr_idx] <= i_wr_data;
        end
    end

    assign o_rd_data = r_slot[i_rd_idx];
endmodule
`default_nettype wire

[hdl/mnsel_cmp.sv]
// Shared scan comparator: fewest requests (ties later) or most free RAM (ties first).
`default_nettype none
module mnsel_cmp (
    input  wire logic                        i_least,
    input  wire logic                        i_first,
    input  wire logic [mnsel_pkg::RAM_W-1:0] i_cand,
    input  wire logic [mnsel_pkg::RAM_W-1:0] i_best,
    output logic                             o_take
);
    import mnsel_pkg::*;

    always_comb begin
        if (i_first) begin
            o_take = 1'b1;
        end else if (i_least) begin
            o_take = (i_cand <= i_best);
        end else begin
            o_take = (i_cand > i_best);
        end
    end
endmodule
`default_nettype wire

[hdl/memory_node_selector.sv]
// Memory node selector top level: config, sequencer, pick state and result register.
//
//  channel   dir  width          contents
//  s_axis    in   tdata 184      status or consult item, tuser = kind
//  m_axis    out  tdata 56       pick result, tuser = sender_known
//  cfg       in   idx 3, data 16 register writes, no read-back
//
// A status transfer holds tready low while its slot is updated; a consult
// also passes the scan state when the pick scans the table (least traffic at a
// rescan, most free RAM), one compare per slot in mnsel_cmp, and skips it otherwise.
// The result waits in the output register; a stall holds the sequencer at its
// last step only when the next result meets a still-full register.
// Reset is synchronous, active low, and clears the table at once.
`default_nettype none
module memory_node_selector #(
    parameter int NODE_COUNT = 4
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // src_node_id, total_ram, free_ram, request_count, request_length
    input  wire logic [mnsel_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // kind
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // chosen_node_id, granted_length
    output logic [mnsel_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // sender_known
    output logic                                     m_axis_tuser,
    input  wire logic                                i_cfg_we,
    input  wire logic [mnsel_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [mnsel_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mnsel_pkg::*;
`include "memory_node_selector_macros.svh"

    localparam int SLOT_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NODE_COUNT - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // configuration
    logic [ID_W-1:0]    r_node_id [NODE_COUNT];
    logic [MODE_W-1:0]  r_mode;
    logic [PHASE_W-1:0] r_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODE_COUNT; i++) begin
                r_node_id[i] <= ID_W'(i);
            end
            r_mode     <= MODE_RR;
            r_interval <= 16'd1;
        end else if (i_cfg_we) begin
            if (int'(i_cfg_idx) < NODE_COUNT) begin
                r_node_id[i_cfg_idx[SLOT_W-1:0]] <= i_cfg_data[ID_W-1:0];
            end else if (i_cfg_idx == CFG_MODE) begin
                r_mode <= i_cfg_data[MODE_W-1:0];
            end else if (i_cfg_idx == CFG_INTERVAL) begin
                r_interval <= i_cfg_data;
            end
        end
    end

    // held item
    logic             r_kind;
    logic [ID_W-1:0]  r_src;
    t_slot_data       r_item;
    logic [RAM_W-1:0] r_len;
    logic             r_known;

    // sequencer and pick state
    logic [1:0]         r_state,     n_state;
    logic [SLOT_W-1:0]  r_scan_idx,  n_scan_idx;
    logic [SLOT_W-1:0]  r_best_idx,  n_best_idx;
    logic [RAM_W-1:0]   r_best_val,  n_best_val;
    logic [PHASE_W-1:0] r_rr_phase,  n_rr_phase;
    logic [SLOT_W-1:0]  r_rr_slot,   n_rr_slot;
    logic [PHASE_W-1:0] r_tr_phase,  n_tr_phase;
    logic [ID_W-1:0]    r_last,      n_last;
    logic               r_out_valid, n_out_valid;
    logic [ID_W-1:0]    r_out_id;
    logic [RAM_W-1:0]   r_out_len;
    logic               r_out_known;

    logic               w_accept;
    logic               w_hit;
    logic [SLOT_W-1:0]  w_hit_idx;
    logic               w_least;
    logic               w_need_scan;
    logic [PHASE_W-1:0] w_ival;
    logic [PHASE_W-1:0] w_rr_inc;
    logic [SLOT_W:0]    w_slot_inc;
    logic [SLOT_W-1:0]  w_rr_slot_nx;
    logic [PHASE_W-1:0] w_tr_inc;
    logic [ID_W-1:0]    w_pick;
    logic               w_load;
    logic [RAM_W-1:0]   w_cand;
    logic               w_take;
    t_slot_data         w_rd;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = NODE_COUNT - 1; i >= 0; i--) begin
            if (r_node_id[i] == r_src) begin
                w_hit     = 1'b1;
                w_hit_idx = SLOT_W'(i);
            end
        end
    end

    mnsel_table #(
        .DEPTH (NODE_COUNT),
        .IDX_W (SLOT_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   ((r_state == S_UPD) && w_hit),
        .i_wr_idx  (w_hit_idx),
        .i_wr_data (r_item),
        .i_rd_idx  (r_scan_idx),
        .o_rd_data (w_rd)
    );

    assign w_least = (r_mode == MODE_TRAFFIC);
    assign w_cand  = w_least ? {{(RAM_W - CNT_W){1'b0}}, w_rd.request_count} : w_rd.free_ram;

    mnsel_cmp u_cmp (
        .i_least (w_least),
        .i_first (r_scan_idx == '0),
        .i_cand  (w_cand),
        .i_best  (r_best_val),
        .o_take  (w_take)
    );

    assign w_ival      = (r_interval == '0) ? 16'd1 : r_interval;
    assign w_need_scan = (r_mode != MODE_RR) && !(w_least && (r_tr_phase != '0));
    assign w_rr_inc    = r_rr_phase + 16'd1;
    assign w_slot_inc  = {1'b0, r_rr_slot} + {{SLOT_W{1'b0}}, 1'b1};
    assign w_tr_inc    = r_tr_phase + 16'd1;

    always_comb begin
        n_rr_phase   = r_rr_phase;
        n_rr_slot    = r_rr_slot;
        n_tr_phase   = r_tr_phase;
        n_last       = r_last;
        w_rr_slot_nx = r_rr_slot;
        if ((w_rr_inc >= w_ival) || (w_rr_inc == '0)) begin
            w_rr_slot_nx = (int'(w_slot_inc) >= NODE_COUNT) ? '0 : w_slot_inc[SLOT_W-1:0];
        end
        case (r_mode)
            MODE_RR: begin
                w_pick = r_node_id[w_rr_slot_nx];
            end
            MODE_TRAFFIC: begin
                w_pick = (r_tr_phase == '0) ? r_node_id[r_best_idx] : r_last;
            end
            default: begin
                w_pick = r_node_id[r_best_idx];
            end
        endcase
        w_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
        if (w_load) begin
            if (r_mode == MODE_RR) begin
                n_rr_slot  = w_rr_slot_nx;
                n_rr_phase = ((w_rr_inc >= w_ival) || (w_rr_inc == '0)) ? '0 : w_rr_inc;
            end else if (w_least) begin
                n_last     = w_pick;
                n_tr_phase = (w_tr_inc >= w_ival) ? '0 : w_tr_inc;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_scan_idx  = r_scan_idx;
        n_best_idx  = r_best_idx;
        n_best_val  = r_best_val;
        n_out_valid = r_out_valid;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_scan_idx = '0;
                if (r_kind == KIND_STATUS) begin
                    n_state = S_IDLE;
                end else if (w_need_scan) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (w_take) begin
                    n_best_idx = r_scan_idx;
                    n_best_val = w_cand;
                end
                if (r_scan_idx == LAST_SLOT) begin
                    n_state = S_DONE;
                end else begin
                    n_scan_idx = r_scan_idx + {{(SLOT_W - 1){1'b0}}, 1'b1};
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan_idx  <= '0;
            r_best_idx  <= '0;
            r_rr_phase  <= '0;
            r_rr_slot   <= '0;
            r_tr_phase  <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan_idx  <= n_scan_idx;
            r_best_idx  <= n_best_idx;
            r_rr_phase  <= n_rr_phase;
            r_rr_slot   <= n_rr_slot;
            r_tr_phase  <= n_tr_phase;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_val <= n_best_val;
        if (w_accept) begin
            r_kind               <= s_axis_tuser;
            r_src                <= s_axis_tdata[7:0];
            r_item.total_ram     <= s_axis_tdata[55:8];
            r_item.free_ram      <= s_axis_tdata[103:56];
            r_item.request_count <= s_axis_tdata[135:104];
            r_len                <= s_axis_tdata[183:136];
        end
        if (r_state == S_UPD) begin
            r_known <= w_hit;
        end
        if (w_load) begin
            r_out_id    <= w_pick;
            r_out_len   <= r_len;
            r_out_known <= r_known;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_id};
    assign m_axis_tuser  = r_out_known;

    `MNSEL_ASSERT_NEXT(a_accept_to_upd, i_clk, i_rst_n, w_accept, r_state == S_UPD,
        "transfer not followed by update")
    `MNSEL_ASSERT_NEXT(a_status_no_result, i_clk, i_rst_n,
        (r_state == S_UPD) && (r_kind == KIND_STATUS), r_state == S_IDLE,
        "status item did not return to idle")
    `MNSEL_ASSERT_NOW(a_rr_slot_range, i_clk, i_rst_n, 1'b1, int'(r_rr_slot) < NODE_COUNT,
        "round robin slot out of range")
    `MNSEL_ASSERT_NOW(a_scan_range, i_clk, i_rst_n, r_state == S_SCAN,
        int'(r_scan_idx) < NODE_COUNT, "scan index out of range")
endmodule
`default_nettype wire

[verif/memory_node_selector_checker.sv]
// Transfer monitor, pick predictor and result scoreboard for the memory node selector.
module memory_node_selector_checker #(
    parameter int NODES = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    input  wire logic                             i_s_tready,
    input  wire logic [mnsel_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                             i_s_tuser,
    input  wire logic                             i_m_tvalid,
    input  wire logic                             i_m_tready,
    input  wire logic [mnsel_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  wire logic                             i_m_tuser,
    input  wire logic                             i_cfg_we,
    input  wire logic [mnsel_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mnsel_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                    o_pending,
    output int                                    o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import mnsel_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]  node;
        logic [RAM_W-1:0] length;
        logic             known;
    } t_grant;

    t_grant              grant_q[$];
    logic [ID_W-1:0]     node_id[NODES];
    logic [MODE_W-1:0]   mode;
    logic [PHASE_W-1:0]  interval;
    t_slot_data          slot[NODES];
    logic [PHASE_W-1:0]  rr_phase;
    logic [PHASE_W-1:0]  traffic_phase;
    int                  rr_slot;
    logic [ID_W-1:0]     last_pick;

    function automatic int find_slot(input logic [ID_W-1:0] id);
        for (int i = 0; i < NODES; i++) begin
            if (node_id[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Advances the counters of the active mode and returns the chosen id.
    function automatic logic [ID_W-1:0] predict_pick();
        int best;
        logic [PHASE_W-1:0] ival;
        ival = (interval == '0) ? PHASE_W'(1) : interval;
        best = 0;
        if (mode == MODE_RR) begin
            rr_phase = rr_phase + 1'b1;
            if (rr_phase >= ival || rr_phase == '0) begin
                rr_phase = '0;
                rr_slot  = (rr_slot + 1 >= NODES) ? 0 : rr_slot + 1;
            end
            return node_id[rr_slot];
        end
        if (mode == MODE_TRAFFIC) begin
            if (traffic_phase == '0) begin
                for (int i = 0; i < NODES; i++) begin
                    if (slot[i].request_count <= slot[best].request_count) begin
                        best = i;
                    end
                end
                last_pick = node_id[best];
            end
            traffic_phase = traffic_phase + 1'b1;
            if (traffic_phase >= ival) begin
                traffic_phase = '0;
            end
            return last_pick;
        end
        for (int i = 0; i < NODES; i++) begin
            if (slot[i].free_ram > slot[best].free_ram) begin
                best = i;
            end
        end
        return node_id[best];
    endfunction

    always @(posedge i_clk) begin
        t_grant got;
        t_grant want;
        int     s;
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                node_id[i] = ID_W'(i);
                slot[i]    = '0;
            end
            mode          = MODE_RR;
            interval      = PHASE_W'(1);
            rr_phase      = '0;
            traffic_phase = '0;
            rr_slot       = 0;
            last_pick     = '0;
            grant_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.node   = i_m_tdata[ID_W-1:0];
                got.length = i_m_tdata[ID_W +: RAM_W];
                got.known  = i_m_tuser;
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected result transfer node %h length %h known %b",
                             $time, got.node, got.length, got.known);
                    o_fail_count++;
                end else begin
                    want = grant_q.pop_front();
                    if (got.node !== want.node) begin
                        $display("%0t: chosen node expected %h actual %h",
                                 $time, want.node, got.node);
                        o_fail_count++;
                    end
                    if (got.length !== want.length) begin
                        $display("%0t: granted length expected %h actual %h",
                                 $time, want.length, got.length);
                        o_fail_count++;
                    end
                    if (got.known !== want.known) begin
                        $display("%0t: sender known expected %b actual %b",
                                 $time, want.known, got.known);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx < CFG_MODE) begin
                    node_id[i_cfg_idx] = i_cfg_data[ID_W-1:0];
                end else if (i_cfg_idx == CFG_MODE) begin
                    mode = i_cfg_data[MODE_W-1:0];
                end else if (i_cfg_idx == CFG_INTERVAL) begin
                    interval = i_cfg_data[PHASE_W-1:0];
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                s = find_slot(i_s_tdata[ID_W-1:0]);
                if (s >= 0) begin
                    slot[s].total_ram     = i_s_tdata[ID_W +: RAM_W];
                    slot[s].free_ram      = i_s_tdata[ID_W+RAM_W +: RAM_W];
                    slot[s].request_count = i_s_tdata[ID_W+2*RAM_W +: CNT_W];
                end
                if (i_s_tuser == KIND_CONSULT) begin
                    want.node   = predict_pick();
                    want.length = i_s_tdata[ID_W+2*RAM_W+CNT_W +: RAM_W];
                    want.known  = (s >= 0);
                    grant_q.push_back(want);
                end
            end
        end
        o_pending = grant_q.size();
    end
endmodule

[verif/memory_node_selector_tb.sv]
// Top of the memory node selector testbench: clock, reset, stimulus, sink stalls and verdict.
module memory_node_selector_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mnsel_pkg::*;

    localparam int                NODES     = 4;
    localparam logic [MODE_W-1:0] MODE_FREE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int             pending;
    int             fail_count;
    bit             stall_req;
    bit             sender_eager;
    logic [ID_W-1:0] cur_ids[NODES];

    memory_node_selector #(.NODE_COUNT(NODES)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    memory_node_selector_checker #(.NODES(NODES)) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [IN_DATA_W-1:0] noise_word();
        logic [191:0] w;
        for (int k = 0; k < 6; k++) begin
            w[k*32 +: 32] = $urandom;
        end
        return w[IN_DATA_W-1:0];
    endfunction

    function automatic logic [RAM_W-1:0] ram_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return RAM_W'($urandom_range(0, 3));
            default: return RAM_W'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] count_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return CNT_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        if (idx < CFG_MODE) begin
            cur_ids[idx] = data[ID_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_ids(input logic [ID_W-1:0] a, b, c, d);
        write_reg(CFG_IDX_W'(0), CFG_DATA_W'(a));
        write_reg(CFG_IDX_W'(1), CFG_DATA_W'(b));
        write_reg(CFG_IDX_W'(2), CFG_DATA_W'(c));
        write_reg(CFG_IDX_W'(3), CFG_DATA_W'(d));
    endtask

    // Valid stays high after a transfer so that back-to-back items need no extra edge.
    task automatic send_item(input logic kind, input logic [ID_W-1:0] src,
                             input logic [RAM_W-1:0] total, free,
                             input logic [CNT_W-1:0] cnt, input logic [RAM_W-1:0] len);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = {len, cnt, free, total, src};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic sender_gap();
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (sender_eager || r < 55) n = 0;
        else if (r < 85) n = $urandom_range(1, 3);
        else if (r < 97) n = $urandom_range(4, 10);
        else n = $urandom_range(20, 60);
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            s_axis_tuser  = 1'($urandom_range(0, 1));
            s_axis_tdata  = noise_word();
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // A status item can still be in flight after the last result, hence the tail.
    task automatic drain(input int tail);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (tail) @(negedge i_clk);
    endtask

    task automatic send_random_item();
        logic            kind;
        logic [ID_W-1:0] src;
        kind = ($urandom_range(0, 99) < 60) ? KIND_CONSULT : KIND_STATUS;
        if ($urandom_range(0, 3) != 0) src = cur_ids[$urandom_range(0, NODES - 1)];
        else src = ID_W'($urandom_range(0, 255));
        send_item(kind, src, ram_value(), ram_value(), count_value(), ram_value());
        sender_gap();
    endtask

    initial begin
        logic [ID_W-1:0] id_pick[NODES];
        logic [CFG_DATA_W-1:0] ival;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = KIND_STATUS;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        stall_req     = 1'b0;
        sender_eager  = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            cur_ids[i] = ID_W'(i);
        end
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: round robin, interval one, ids 0..3
        send_item(KIND_STATUS, 8'd0, '1, '1, '1, '0);
        send_item(KIND_STATUS, 8'd3, '0, '0, '0, '1);
        send_item(KIND_CONSULT, 8'd1, '0, '0, '0, '1);
        send_item(KIND_CONSULT, 8'd200, '1, '1, '1, '0);
        send_item(KIND_STATUS, 8'd255, '1, '1, '1, '1);
        send_item(KIND_CONSULT, 8'd2, 48'h5, 48'h7, 32'd9, 48'h123456789abc);
        send_item(KIND_CONSULT, 8'd3, 48'h1, 48'h2, 32'd3, 48'h1);
        drain(12);

        // duplicate ids, least traffic with rescan every second pick
        set_ids(8'd7, 8'd7, 8'd255, 8'd0);
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_TRAFFIC));
        write_reg(CFG_INTERVAL, 16'd2);
        send_item(KIND_CONSULT, 8'd7, '0, '0, 32'd5, '1);
        send_item(KIND_CONSULT, 8'd255, '0, '0, 32'd0, 48'h10);
        send_item(KIND_CONSULT, 8'd0, '0, '0, 32'd0, 48'h20);
        send_item(KIND_STATUS, 8'd7, '0, '0, 32'd0, '0);
        send_item(KIND_CONSULT, 8'd255, '0, '0, 32'd0, 48'h30);
        drain(12);

        // most free RAM, ties to the first slot
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_FREE));
        write_reg(CFG_INTERVAL, 16'd3);
        send_item(KIND_STATUS, 8'd7, '1, 48'd100, '1, '0);
        send_item(KIND_STATUS, 8'd255, '1, 48'd100, '1, '0);
        send_item(KIND_CONSULT, 8'd0, '1, 48'd100, '1, 48'h40);
        send_item(KIND_CONSULT, 8'd0, '1, '1, '1, 48'h50);
        drain(12);

        write_reg(CFG_MODE, CFG_DATA_W'(MODE_SPARE));
        send_item(KIND_CONSULT, 8'd255, '0, '1, '0, 48'h60);
        send_item(KIND_STATUS, 8'd0, '0, '0, '0, '0);
        drain(12);

        // interval zero behaves as one
        write_reg(CFG_MODE, CFG_DATA_W'(MODE_RR));
        write_reg(CFG_INTERVAL, 16'd0);
        repeat (3) send_item(KIND_CONSULT, 8'd9, '0, '0, '0, 48'h70);
        drain(12);

        write_reg(CFG_MODE, CFG_DATA_W'(MODE_TRAFFIC));
        write_reg(CFG_INTERVAL, 16'hffff);
        send_item(KIND_CONSULT, 8'd0, '0, '0, '1, 48'h80);
        send_item(KIND_CONSULT, 8'd7, '0, '0, '0, 48'h90);
        send_item(KIND_CONSULT, 8'd255, '0, '0, '1, 48'ha0);
        drain(12);

        for (int phase = 0; phase < 8; phase++) begin
            for (int i = 0; i < NODES; i++) begin
                if (i > 0 && $urandom_range(0, 3) == 0) id_pick[i] = id_pick[i - 1];
                else id_pick[i] = ID_W'($urandom_range(0, 255));
            end
            set_ids(id_pick[0], id_pick[1], id_pick[2], id_pick[3]);
            write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 3)));
            case ($urandom_range(0, 5))
                0: ival = 16'd1;
                1, 2: ival = CFG_DATA_W'($urandom_range(2, 4));
                3: ival = 16'd0;
                4: ival = 16'hffff;
                default: ival = CFG_DATA_W'($urandom_range(5, 40));
            endcase
            write_reg(CFG_INTERVAL, ival);
            sender_eager = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 80; n++) begin
                if (phase == 1 && n == 5) stall_req = 1'b1;
                send_random_item();
            end
            drain(12);
        end

        drain(20);
        if (fail_count == 0 && pending == 0) begin
            $display("** memory_node_selector: PASSED **");
        end else begin
            $display("** memory_node_selector: FAILED **");
        end
        $finish;
    end

    initial begin
        int n;
        int r;
        m_axis_tready = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            @(negedge i_clk);
            if (stall_req) begin
                stall_req     = 1'b0;
                m_axis_tready = 1'b0;
                n = 300;
            end else if (r < 50) begin
                m_axis_tready = 1'b1;
                n = $urandom_range(1, 8);
            end else if (r < 80) begin
                m_axis_tready = 1'b0;
                n = $urandom_range(1, 3);
            end else if (r < 95) begin
                m_axis_tready = 1'b1;
                n = $urandom_range(30, 80);
            end else begin
                m_axis_tready = 1'b0;
                n = $urandom_range(20, 60);
            end
            repeat (n - 1) @(negedge i_clk);
        end
    end

    initial begin
        #1_000_000;
        $display("** memory_node_selector: FAILED **");
        $finish;
    end
endmodule
